### rtl/core/mtg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MT19937 generator package
// Sizes, constants, sequencer states and the word-level twist, seed and
// temper functions.
// ----------------------------------------------------------------------------
package mtg_pkg;

  localparam int STATE_WORDS  = 624;
  localparam int SHIFT_OFFSET = 397;
  localparam int WORD_W       = 32;
  localparam int POS_W        = $clog2(STATE_WORDS);

  localparam logic [WORD_W-1:0] TWIST_XOR  = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] SEED_MULT  = 32'h6c07_8965;
  localparam logic [WORD_W-1:0] TEMPER_B   = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C   = 32'hefc6_0000;
  localparam logic [WORD_W-1:0] HIGH_BIT   = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LOW_BITS   = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] RESET_SEED = 32'd5489;

  localparam logic CMD_RESEED = 1'b0;
  localparam logic CMD_DRAW   = 1'b1;

  typedef enum logic [2:0] {
    ST_SEED,
    ST_IDLE,
    ST_RD_NEXT,
    ST_RD_FAR,
    ST_TWIST
  } state_t;

  function automatic logic [WORD_W-1:0] seed_word(input logic [WORD_W-1:0] prev,
                                                  input logic [POS_W-1:0]  idx);
    logic [WORD_W-1:0] mix;
    mix = prev ^ (prev >> 30);
    return (SEED_MULT * mix) + WORD_W'(idx);
  endfunction

  function automatic logic [WORD_W-1:0] twist_word(input logic [WORD_W-1:0] cur,
                                                   input logic [WORD_W-1:0] nxt,
                                                   input logic [WORD_W-1:0] far);
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] v;
    y = (cur & HIGH_BIT) | (nxt & LOW_BITS);
    v = far ^ (y >> 1);
    if (y[0]) begin
      v = v ^ TWIST_XOR;
    end
    return v;
  endfunction

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

### rtl/core/mtg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MT19937 generator channels
// Command channel (command, seed) and result channel (random word).
// ----------------------------------------------------------------------------
interface mtg_cmd_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] seed_value;

  modport source (output valid, output command, output seed_value, input ready);
  modport sink   (input valid, input command, input seed_value, output ready);
endinterface

interface mtg_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

### rtl/core/mtg_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mtg_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 624,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/mersenne_twister_generator.sv
`timescale 1ns / 1ps
// Draw: three reads of the single-read-port state RAM, then twist, write back
//   and temper; no new item is accepted until the result is registered.
// Reseed: fills all 624 state words, one seed word written per cycle, no
//   result; the next item is accepted once the fill completes.
// Reset: runs the fill with seed 5489; in_chan.ready stays low until it
//   completes. A waiting result holds the final cycle of a draw.
// ----------------------------------------------------------------------------
// MT19937 pseudorandom word generator
// State words live in one RAM and are twisted in place, one word per draw.
// ----------------------------------------------------------------------------
module mersenne_twister_generator
  import mtg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  mtg_cmd_if.sink           in_chan,
  mtg_word_if.source        out_chan
);

  state_t            state_r, state_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  cnt_r, cnt_nxt;
  logic [WORD_W-1:0] seed_r, seed_nxt;
  logic [WORD_W-1:0] prev_r, prev_nxt;
  logic [WORD_W-1:0] cur_r, cur_nxt;
  logic [WORD_W-1:0] nxtw_r, nxtw_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_word_r, out_word_nxt;

  logic              in_acc;
  logic              out_free;
  logic [POS_W-1:0]  pos_inc;
  logic [POS_W:0]    far_sum;
  logic [POS_W-1:0]  far_addr;
  logic [WORD_W-1:0] seed_data;
  logic [WORD_W-1:0] tw_data;

  logic              ram_we;
  logic [POS_W-1:0]  ram_wa;
  logic [WORD_W-1:0] ram_wd;
  logic              ram_re;
  logic [POS_W-1:0]  ram_ra;
  logic [WORD_W-1:0] ram_rd;

  mtg_ram #(.WIDTH(WORD_W), .DEPTH(STATE_WORDS)) u_state_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_en   (ram_re),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  assign in_chan.ready        = (state_r == ST_IDLE);
  assign in_acc               = in_chan.valid && in_chan.ready;
  assign out_chan.valid       = out_valid_r;
  assign out_chan.random_word = out_word_r;
  assign out_free             = !out_valid_r || out_chan.ready;

  assign pos_inc  = (pos_r == POS_W'(STATE_WORDS - 1)) ? '0 : pos_r + POS_W'(1);
  assign far_sum  = {1'b0, pos_r} + (POS_W + 1)'(SHIFT_OFFSET);
  assign far_addr = (far_sum >= (POS_W + 1)'(STATE_WORDS)) ?
                    POS_W'(far_sum - (POS_W + 1)'(STATE_WORDS)) : far_sum[POS_W-1:0];

  assign seed_data = (cnt_r == '0) ? seed_r : seed_word(prev_r, cnt_r);
  assign tw_data   = twist_word(cur_r, nxtw_r, ram_rd);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_SEED: begin
        if (cnt_r == POS_W'(STATE_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_chan.command == CMD_DRAW) ? ST_RD_NEXT : ST_SEED;
        end
      end
      ST_RD_NEXT: state_nxt = ST_RD_FAR;
      ST_RD_FAR:  state_nxt = ST_TWIST;
      ST_TWIST: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    seed_nxt      = seed_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    nxtw_nxt      = nxtw_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_word_nxt  = out_word_r;
    ram_we        = 1'b0;
    ram_wa        = pos_r;
    ram_wd        = tw_data;
    ram_re        = 1'b0;
    ram_ra        = pos_r;
    case (state_r)
      ST_SEED: begin
        ram_we   = 1'b1;
        ram_wa   = cnt_r;
        ram_wd   = seed_data;
        prev_nxt = seed_data;
        cnt_nxt  = cnt_r + POS_W'(1);
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_chan.command == CMD_DRAW) begin
            ram_re = 1'b1;
          end else begin
            seed_nxt = in_chan.seed_value;
            cnt_nxt  = '0;
            pos_nxt  = '0;
          end
        end
      end
      ST_RD_NEXT: begin
        cur_nxt = ram_rd;
        ram_re  = 1'b1;
        ram_ra  = pos_inc;
      end
      ST_RD_FAR: begin
        nxtw_nxt = ram_rd;
        ram_re   = 1'b1;
        ram_ra   = far_addr;
      end
      ST_TWIST: begin
        if (out_free) begin
          ram_we        = 1'b1;
          out_valid_nxt = 1'b1;
          out_word_nxt  = temper(tw_data);
          pos_nxt       = pos_inc;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SEED;
      pos_r       <= '0;
      cnt_r       <= '0;
      seed_r      <= RESET_SEED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      seed_r      <= seed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r     <= prev_nxt;
    cur_r      <= cur_nxt;
    nxtw_r     <= nxtw_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule

### rtl/core/mtg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MT19937 generator port checker
// Watches the top-level channels for handshake and sequencing slips.
// ----------------------------------------------------------------------------
module mtg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result item dropped or changed while stalled");

  a_fill_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready before state fill completes");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted before first finished");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared in the cycle after accept");

endmodule

bind mersenne_twister_generator mtg_checker u_mtg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_word  (out_chan.random_word)
);

### bench/mt_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MT19937 word stream checker
// Watches the command and word channels, keeps its own copy of the 624-word
// twister store and read position, predicts the tempered word of every
// accepted draw and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module mt_stream_checker
  import mtg_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  mtg_cmd_if   cmd_chan,
  mtg_word_if  word_chan,
  output int   fail_count,
  output int   words_pending
);

  logic [WORD_W-1:0] twister_store [STATE_WORDS];
  logic [POS_W-1:0]  next_index;
  logic [WORD_W-1:0] predicted_words [$];
  int                mismatches = 0;
  int                pending_now = 0;

  assign fail_count    = mismatches;
  assign words_pending = pending_now;

  function automatic void load_seed(input logic [WORD_W-1:0] seed);
    logic [WORD_W-1:0] prev;
    twister_store[0] = seed;
    for (int i = 1; i < STATE_WORDS; i++) begin
      prev = twister_store[i-1];
      twister_store[i] = SEED_MULT * (prev ^ (prev >> 30)) + WORD_W'(i);
    end
    next_index = '0;
  endfunction

  function automatic void regenerate_store();
    logic [WORD_W-1:0] mixed;
    logic [WORD_W-1:0] fresh;
    int                succ;
    int                offset_idx;
    for (int i = 0; i < STATE_WORDS; i++) begin
      succ       = (i + 1) % STATE_WORDS;
      offset_idx = (i + SHIFT_OFFSET) % STATE_WORDS;
      mixed = (twister_store[i] & HIGH_BIT) | (twister_store[succ] & LOW_BITS);
      fresh = twister_store[offset_idx] ^ (mixed >> 1);
      if (mixed[0]) begin
        fresh = fresh ^ TWIST_XOR;
      end
      twister_store[i] = fresh;
    end
  endfunction

  function automatic logic [WORD_W-1:0] tempered(input logic [WORD_W-1:0] raw);
    logic [WORD_W-1:0] t;
    t = raw ^ (raw >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    t = t ^ (t >> 18);
    return t;
  endfunction

  function automatic logic [WORD_W-1:0] next_random_word();
    logic [WORD_W-1:0] word;
    if (next_index == '0) begin
      regenerate_store();
    end
    word = tempered(twister_store[next_index]);
    if (int'(next_index) == STATE_WORDS - 1) begin
      next_index = '0;
    end else begin
      next_index = next_index + 1'b1;
    end
    return word;
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("%0t: %s: got %08h, predicted %08h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      load_seed(RESET_SEED);
      predicted_words.delete();
    end else begin
      if (cmd_chan.valid && cmd_chan.ready) begin
        if (cmd_chan.command == CMD_RESEED) begin
          load_seed(cmd_chan.seed_value);
        end else begin
          predicted_words.push_back(next_random_word());
        end
      end
      if (word_chan.valid && word_chan.ready) begin
        if (predicted_words.size() == 0) begin
          report_mismatch("word with no draw pending", word_chan.random_word, '0);
        end else if (word_chan.random_word !== predicted_words[0]) begin
          report_mismatch("random_word mismatch", word_chan.random_word,
                          predicted_words[0]);
          void'(predicted_words.pop_front());
        end else begin
          void'(predicted_words.pop_front());
        end
      end
    end
    pending_now = predicted_words.size();
  end

endmodule

### bench/mersenne_twister_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MT19937 generator testbench
// Drives reseed and draw commands through directed cases and random phases
// with varying sender gaps and receiver stalls, including one long receiver
// hold-off; the stream checker predicts and compares every word.
// ----------------------------------------------------------------------------
module mersenne_twister_generator_tb;
  import mtg_pkg::*;

  logic clk;
  logic rst_n;

  mtg_cmd_if  cmd_chan ();
  mtg_word_if word_chan ();

  int fail_count;
  int words_pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  bit hold_request   = 1'b0;
  bit hold_taken     = 1'b0;

  mersenne_twister_generator u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (cmd_chan),
    .out_chan (word_chan)
  );

  mt_stream_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_chan      (cmd_chan),
    .word_chan     (word_chan),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    word_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        word_chan.ready = 1'b0;
        hold_left--;
      end else if (hold_request && !hold_taken) begin
        word_chan.ready = 1'b0;
        hold_taken = 1'b1;
        hold_left  = 300;
      end else begin
        word_chan.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_item(input logic cmd, input logic [31:0] seed);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_chan.valid = 1'b0;
      @(negedge clk);
    end
    cmd_chan.valid      = 1'b1;
    cmd_chan.command    = cmd;
    cmd_chan.seed_value = seed;
    @(posedge clk);
    while (!cmd_chan.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic draw_words(input int count);
    for (int n = 0; n < count; n++) begin
      send_item(CMD_DRAW, $urandom);
    end
  endtask

  task automatic mixed_commands(input int count, input int reseed_pct);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < reseed_pct) begin
        send_item(CMD_RESEED, $urandom);
      end else begin
        send_item(CMD_DRAW, $urandom);
      end
    end
  endtask

  initial begin
    int waited;
    rst_n               = 1'b0;
    cmd_chan.valid      = 1'b0;
    cmd_chan.command    = CMD_DRAW;
    cmd_chan.seed_value = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // directed: sequence after reset, seed extremes, back-to-back reseeds
    send_item(CMD_DRAW, 32'h0000_0000);
    send_item(CMD_DRAW, 32'hffff_ffff);
    send_item(CMD_DRAW, $urandom);
    send_item(CMD_RESEED, 32'h0000_0000);
    draw_words(2);
    send_item(CMD_RESEED, 32'hffff_ffff);
    draw_words(2);
    send_item(CMD_RESEED, RESET_SEED);
    draw_words(2);
    send_item(CMD_RESEED, 32'h8000_0000);
    send_item(CMD_RESEED, 32'h7fff_ffff);
    send_item(CMD_DRAW, 32'hffff_ffff);
    send_item(CMD_RESEED, 32'h0000_0001);
    send_item(CMD_DRAW, 32'h0000_0000);
    send_item(CMD_RESEED, 32'haaaa_5555);
    draw_words(2);
    send_item(CMD_RESEED, 32'h5555_aaaa);
    send_item(CMD_DRAW, $urandom);

    // no idling: run past the position wrap
    send_item(CMD_RESEED, $urandom);
    draw_words(700);
    mixed_commands(150, 3);

    send_idle_pct = 88;
    mixed_commands(250, 3);

    send_idle_pct  = 0;
    recv_stall_pct = 88;
    mixed_commands(250, 3);

    send_idle_pct  = 14;
    recv_stall_pct = 14;
    mixed_commands(250, 3);

    // hold off the receiver while draws keep coming
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b1;
    draw_words(80);

    mixed_commands(50, 3);
    send_item(CMD_DRAW, $urandom);
    cmd_chan.valid = 1'b0;

    waited = 0;
    while (words_pending != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);

    if (fail_count == 0 && words_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
